/* rtl/cca_pkg.sv */
// ----------------------------------------------------------------------------
// cca_pkg
// Shared types, constants and the binary64 add used by the accumulator lanes.
// ----------------------------------------------------------------------------
package cca_pkg;

  localparam int unsigned FpW   = 64;
  localparam int unsigned ExpW  = 11;
  localparam int unsigned FracW = 52;
  localparam int unsigned ExtW  = FracW + 5;

  localparam logic [ExpW-1:0] ExpMax     = '1;
  localparam logic [FpW-1:0]  DefaultNan = 64'hFFF8_0000_0000_0000;
  localparam logic [FpW-1:0]  PosZero    = '0;

  typedef logic [FpW-1:0] fp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIFF,
    ST_LOST,
    ST_COMP,
    ST_FIN
  } cca_step_t;

  typedef struct packed {
    cca_step_t step;
  } lane_ctrl_t;

  typedef struct packed {
    logic bad_update;
    logic bad_total;
  } lane_stat_t;

  function automatic logic fp_is_nan(input fp_t a);
    return (a[62:52] == ExpMax) && (a[51:0] != '0);
  endfunction

  function automatic logic fp_is_finite(input fp_t a);
    return a[62:52] != ExpMax;
  endfunction

  function automatic logic fp_mag_ge(input fp_t a, input fp_t b);
    return !fp_is_nan(a) && !fp_is_nan(b) && (a[62:0] >= b[62:0]);
  endfunction

  function automatic fp_t fp_add(input fp_t a, input fp_t b);
    fp_t               x, y, r;
    logic [ExpW:0]     ex, ey, d, e, sh;
    logic [FracW:0]    sx, sy;
    logic [ExtW-2:0]   xv, yv, ext, shifted, mask;
    logic [ExtW-1:0]   s;
    logic [ExtW-2:0]   m;
    logic [6:0]        lz;
    logic              found, sticky, rup;
    logic [FracW+1:0]  rnd;
    r = '0;
    if (fp_is_nan(a)) begin
      r = a | (fp_t'(1) << 51);
    end else if (fp_is_nan(b)) begin
      r = b | (fp_t'(1) << 51);
    end else if (a[62:52] == ExpMax) begin
      r = (b[62:52] == ExpMax && a[63] != b[63]) ? DefaultNan : a;
    end else if (b[62:52] == ExpMax) begin
      r = b;
    end else begin
      if (a[62:0] >= b[62:0]) begin
        x = a;
        y = b;
      end else begin
        x = b;
        y = a;
      end
      ex = {1'b0, (x[62:52] == '0) ? 11'd1 : x[62:52]};
      ey = {1'b0, (y[62:52] == '0) ? 11'd1 : y[62:52]};
      sx = {x[62:52] != '0, x[51:0]};
      sy = {y[62:52] != '0, y[51:0]};
      d  = ex - ey;
      xv = {sx, 3'b000};
      ext = {sy, 3'b000};
      if (d >= 12'(ExtW - 1)) begin
        shifted = '0;
        sticky  = |ext;
      end else begin
        shifted = ext >> d;
        mask    = ~(('1) << d);
        sticky  = |(ext & mask);
      end
      yv = {shifted[ExtW-2:1], shifted[0] | sticky};
      if (x[63] == y[63]) s = {1'b0, xv} + {1'b0, yv};
      else                s = {1'b0, xv} - {1'b0, yv};
      if (s == '0) begin
        r = {x[63] & y[63], 63'b0};
      end else begin
        if (s[ExtW-1]) begin
          m = {s[ExtW-1:2], s[1] | s[0]};
          e = ex + 12'd1;
        end else begin
          lz = '0;
          found = 1'b0;
          for (int i = ExtW - 2; i >= 0; i--) begin
            if (!found && s[i]) begin
              found = 1'b1;
              lz = 7'(ExtW - 2 - i);
            end
          end
          sh = ({5'b0, lz} < ex - 12'd1) ? {5'b0, lz} : ex - 12'd1;
          m  = s[ExtW-2:0] << sh;
          e  = ex - sh;
        end
        rup = m[2] & (m[1] | m[0] | m[3]);
        rnd = {1'b0, m[ExtW-2:3]} + {53'b0, rup};
        if (rnd[FracW+1]) begin
          e = e + 12'd1;
          rnd = rnd >> 1;
        end
        if (e >= 12'(ExpMax)) r = {x[63], ExpMax, 52'b0};
        else r = {x[63], rnd[FracW] ? e[ExpW-1:0] : 11'd0, rnd[FracW-1:0]};
      end
    end
    return r;
  endfunction

  function automatic fp_t fp_sub(input fp_t a, input fp_t b);
    return fp_add(a, fp_is_nan(b) ? b : {~b[63], b[62:0]});
  endfunction

endpackage

/* rtl/cca_in_if.sv */
// ----------------------------------------------------------------------------
// cca_in_if
// Term request channel: one complex binary64 term and its last flag.
// ----------------------------------------------------------------------------
interface cca_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] term_real;
  logic [63:0] term_imag;
  logic        last_term;

  modport source (output valid, term_real, term_imag, last_term, input ready);
  modport sink (input valid, term_real, term_imag, last_term, output ready);
endinterface

/* rtl/cca_out_if.sv */
// ----------------------------------------------------------------------------
// cca_out_if
// Result channel: compensated complex total and status.
// ----------------------------------------------------------------------------
interface cca_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] total_real;
  logic [63:0] total_imag;
  logic        status;

  modport source (output valid, total_real, total_imag, status, input ready);
  modport sink (input valid, total_real, total_imag, status, output ready);
endinterface

/* rtl/cca_lane.sv */
// ----------------------------------------------------------------------------
// cca_lane
// One part of the complex sum: a compensated accumulator that steps one
// binary64 adder through sum, difference, lost bits, correction and total.
// ----------------------------------------------------------------------------
module cca_lane
  import cca_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  lane_ctrl_t ctrl,
  input  fp_t        term,
  output lane_stat_t stat,
  output fp_t        total
);

  fp_t  sum, comp, nxt, big, little, tmp;
  fp_t  op_a, op_b, res;
  logic do_sub;

  always_comb begin
    op_a   = sum;
    op_b   = term;
    do_sub = 1'b0;
    case (ctrl.step)
      ST_DIFF: begin
        op_a   = big;
        op_b   = nxt;
        do_sub = 1'b1;
      end
      ST_LOST: begin
        op_a = tmp;
        op_b = little;
      end
      ST_COMP: begin
        op_a = comp;
        op_b = tmp;
      end
      ST_FIN: begin
        op_a = sum;
        op_b = comp;
      end
      default: ;
    endcase
    res = do_sub ? fp_sub(op_a, op_b) : fp_add(op_a, op_b);
  end

  assign total           = res;
  assign stat.bad_update = !fp_is_finite(nxt) || !fp_is_finite(res);
  assign stat.bad_total  = !fp_is_finite(res);

  always_ff @(posedge clk) begin
    if (rst) begin
      sum  <= PosZero;
      comp <= PosZero;
    end else begin
      case (ctrl.step)
        ST_SUM: begin
          nxt <= res;
          if (fp_mag_ge(sum, term)) begin
            big    <= sum;
            little <= term;
          end else begin
            big    <= term;
            little <= sum;
          end
        end
        ST_DIFF: tmp <= res;
        ST_LOST: tmp <= res;
        ST_COMP: begin
          comp <= res;
          sum  <= nxt;
        end
        ST_FIN: begin
          sum  <= PosZero;
          comp <= PosZero;
        end
        default: ;
      endcase
    end
  end

endmodule

/* rtl/complex_compensated_accumulator.sv */
// ----------------------------------------------------------------------------
// complex_compensated_accumulator
// Compensated (Neumaier) summation of a stream of complex binary64 terms.
//
// Channels: terms (sink) carries term_real, term_imag and last_term;
// totals (source) carries total_real, total_imag and status. A request is
// taken when valid and ready are both high.
// Each term steps through the accept, DIFF, LOST and COMP states: the accept
// cycle adds it to the sum, then the lane adder forms the difference, the
// lost bits and the new correction, on one shared binary64 adder per lane.
// A term marked last then waits in FIN until the output register is free,
// forms sum plus correction there and loads it into the output register;
// the result appears the cycle after. Non-last terms give no result.
// Status is 1 if any term, sum, correction or total of that sum was not
// finite. Reset clears sums, corrections, the error flag and output valid.
// While the receiver stalls, terms are still taken until a total reaches
// FIN; no term is taken while that total waits for the output register.
// ----------------------------------------------------------------------------
module complex_compensated_accumulator
  import cca_pkg::*;
(
  input logic   clk,
  input logic   rst,
  cca_in_if.sink    terms,
  cca_out_if.source totals
);

  cca_step_t  state, state_next;
  lane_ctrl_t ctrl;
  lane_stat_t stat_re, stat_im;
  fp_t        tot_re, tot_im;
  logic       last, err, accept, out_free, load;

  assign terms.ready = (state == ST_IDLE);
  assign accept      = terms.valid && terms.ready;
  assign out_free    = !totals.valid || totals.ready;
  assign load        = (state == ST_FIN) && out_free;

  always_comb begin
    state_next = state;
    ctrl.step  = ST_IDLE;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          ctrl.step  = ST_SUM;
          state_next = ST_DIFF;
        end
      end
      ST_DIFF: begin
        ctrl.step  = ST_DIFF;
        state_next = ST_LOST;
      end
      ST_LOST: begin
        ctrl.step  = ST_LOST;
        state_next = ST_COMP;
      end
      ST_COMP: begin
        ctrl.step  = ST_COMP;
        state_next = last ? ST_FIN : ST_IDLE;
      end
      ST_FIN: begin
        if (out_free) begin
          ctrl.step  = ST_FIN;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  cca_lane u_lane_re (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl),
    .term  (terms.term_real),
    .stat  (stat_re),
    .total (tot_re)
  );

  cca_lane u_lane_im (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl),
    .term  (terms.term_imag),
    .stat  (stat_im),
    .total (tot_im)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      err          <= 1'b0;
      last         <= 1'b0;
      totals.valid <= 1'b0;
    end else begin
      if (accept) begin
        last <= terms.last_term;
        if (!fp_is_finite(terms.term_real) || !fp_is_finite(terms.term_imag)) begin
          err <= 1'b1;
        end
      end
      if (state == ST_COMP && (stat_re.bad_update || stat_im.bad_update)) begin
        err <= 1'b1;
      end
      if (load) begin
        totals.valid <= 1'b1;
        err          <= 1'b0;
      end else if (totals.ready) begin
        totals.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      totals.total_real <= tot_re;
      totals.total_imag <= tot_im;
      totals.status     <= err || stat_re.bad_total || stat_im.bad_total;
    end
  end

endmodule
